>>> rtl/wlsfg_pkg.sv
package wlsfg_pkg;

  localparam int MAX_VARS_DEF = 8;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_ELEM   = 2'd1,
    CMD_FIT    = 2'd2,
    CMD_GRAD   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_NUM_VARS = 1'b0,
    REG_MEANS    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic grad;
  } mac_ctrl_t;

endpackage

>>> rtl/wlsfg_ram.sv
module wlsfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/wlsfg_mac.sv
module wlsfg_mac #(
  parameter int MAX_VARS = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wlsfg_pkg::mac_ctrl_t                 ctl,
  input  logic signed [((DATA_WIDTH < 32) ? DATA_WIDTH : 32):0]   d_i,
  input  logic signed [((DATA_WIDTH < 32) ? DATA_WIDTH : 32):0]   d_j,
  input  logic signed [((DATA_WIDTH < 32) ? DATA_WIDTH : 32)-1:0] g_j,
  input  logic signed [((DATA_WIDTH < 32) ? DATA_WIDTH : 32)-1:0] w,
  output logic [63:0]                          result,
  output logic                                 sat
);
  import wlsfg_pkg::*;

  localparam int VB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int MAXLEN = MAX_VARS * (MAX_VARS + 1) / 2 + MAX_VARS;
  localparam int ACCW = 3 * VB + 2 + 2 * $clog2(MAXLEN) + 1;
  localparam int EXTW = (ACCW + 2 > 82) ? ACCW + 2 : 82;

  logic v1, v2, v3, v4;
  logic signed [2*VB:0]   m1;
  logic signed [VB:0]     x1;
  logic signed [2*VB+1:0] lo, hi;
  logic signed [ACCW-1:0] t, acc;
  logic signed [EXTW-1:0] sx, dbl, sgn, rnd, shf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= ctl.vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (ctl.clr) begin
        acc <= '0;
      end else if (v4) begin
        acc <= acc + t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      m1 <= d_i * w;
      x1 <= ctl.grad ? (VB + 1)'(g_j) : d_j;
    end
    if (v2) begin
      lo <= $signed({1'b0, m1[VB-1:0]}) * x1;
      hi <= $signed(m1[2*VB:VB]) * x1;
    end
    if (v3) begin
      t <= (ACCW'(hi) <<< VB) + ACCW'(lo);
    end
  end

  always_comb begin
    sx = EXTW'(acc);
    dbl = ctl.grad ? (sx <<< 1) : sx;
    sgn = ctl.grad ? -dbl : dbl;
    rnd = sgn + (EXTW'(1) <<< 15);
    shf = rnd >>> 16;
    sat = (|shf[EXTW-1:63]) && !(&shf[EXTW-1:63]);
    if (sat) begin
      result = shf[EXTW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      result = shf[63:0];
    end
  end

endmodule

>>> rtl/wls_fit_and_gradient_form_unit.sv
// Weighted least squares quadratic form unit.
// Input words arrive on the s_ channel; s_tuser carries the command. A weight
// write or an element write gives no result. A fit or gradient command walks
// the L x L weight matrix (L is the vector length set by num_variables and
// means_included), one multiply-accumulate per weight entry, reading the
// weight memory and the element memories once per cycle. Such a command
// then drains the multiply-accumulate pipeline and puts its result word on
// the m_ channel.
// While a command is at work s_tready is low; weight and element writes are
// taken while a finished result still waits on m_.
// A result word holds until m_tready is high; a new result is not loaded
// before the previous one has been taken, so the block waits in that case.
// Reset clears the control state, sets num_variables to 1 and
// means_included to 0, and drops m_tvalid. The memories are not cleared;
// every entry used by a command must be written beforehand.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle; the block does not enforce this.
module wls_fit_and_gradient_form_unit #(
  parameter int MAX_VARS = wlsfg_pkg::MAX_VARS_DEF,
  parameter int DATA_WIDTH = wlsfg_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // row_index, col_index, weight_value, observed_value, implied_value,
  // derivative_value, zero fill
  input  logic [143:0]  s_tdata,
  // cmd
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_value, saturated, zero fill
  output logic [71:0]   m_tdata,
  // result_is_gradient
  output logic          m_tuser
);
  import wlsfg_pkg::*;

  localparam int VB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int MAXLEN = MAX_VARS * (MAX_VARS + 1) / 2 + MAX_VARS;
  localparam int EAW = $clog2(MAXLEN);
  localparam int WDEPTH = MAXLEN * MAXLEN;
  localparam int WAW = $clog2(WDEPTH);
  localparam logic [2:0] DRAIN_CYC = 3'd3;

  state_t state, state_next;
  cmd_t cmd;
  logic [3:0] num_vars;
  logic means;
  logic [5:0] row, col;
  logic signed [VB-1:0] wv, ov, iv, gv;
  logic row_ok, col_ok;
  logic wt_we, el_we, start, issue, load;
  logic [WAW-1:0] wt_waddr, wt_raddr, row_base;
  logic [EAW-1:0] i, j, len_m1;
  logic [9:0] p_eff, len;
  logic [2:0] drain_cnt;
  logic grad;
  logic signed [VB:0] diff_w, d_i, d_j;
  logic signed [VB-1:0] w_rd, g_rd;
  mac_ctrl_t ctl;
  logic [63:0] mac_res, res_r;
  logic mac_sat, sat_r, grad_r;

  assign cmd = cmd_t'(s_tuser);
  assign row = s_tdata[5:0];
  assign col = s_tdata[11:6];
  assign wv = s_tdata[12 +: VB];
  assign ov = s_tdata[44 +: VB];
  assign iv = s_tdata[76 +: VB];
  assign gv = s_tdata[108 +: VB];
  assign row_ok = int'(row) < MAXLEN;
  assign col_ok = int'(col) < MAXLEN;
  assign diff_w = (VB + 1)'(ov) - (VB + 1)'(iv);
  assign wt_waddr = WAW'(row) * WAW'(MAXLEN) + WAW'(col);
  assign wt_raddr = row_base + WAW'(j);

  always_comb begin
    if (num_vars == 4'd0) begin
      p_eff = 10'd1;
    end else if (int'(num_vars) > MAX_VARS) begin
      p_eff = 10'(MAX_VARS);
    end else begin
      p_eff = 10'(num_vars);
    end
    len = ((p_eff * (p_eff + 10'd1)) >> 1) + (means ? p_eff : 10'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars <= 4'd1;
      means <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NUM_VARS: num_vars <= cfg_data;
        REG_MEANS: means <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    wt_we = 1'b0;
    el_we = 1'b0;
    start = 1'b0;
    issue = 1'b0;
    load = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (cmd)
            CMD_WEIGHT: wt_we = row_ok && col_ok;
            CMD_ELEM: el_we = row_ok;
            CMD_FIT, CMD_GRAD: begin
              start = 1'b1;
              state_next = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (i == len_m1 && j == len_m1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRAIN_CYC) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
      row_base <= '0;
      len_m1 <= '0;
      grad <= 1'b0;
      drain_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (start) begin
        i <= '0;
        j <= '0;
        row_base <= '0;
        len_m1 <= EAW'(len - 10'd1);
        grad <= (cmd == CMD_GRAD);
        drain_cnt <= '0;
      end else if (issue) begin
        if (j == len_m1) begin
          j <= '0;
          i <= i + 1'b1;
          row_base <= row_base + WAW'(MAXLEN);
        end else begin
          j <= j + 1'b1;
        end
      end else if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + 3'd1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= mac_res;
      sat_r <= mac_sat;
      grad_r <= grad;
    end
  end

  assign m_tdata = {7'd0, sat_r, res_r};
  assign m_tuser = grad_r;

  assign ctl.clr = start;
  assign ctl.vld = issue;
  assign ctl.grad = grad;

  wlsfg_ram #(.WIDTH(VB), .DEPTH(WDEPTH)) u_weight (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wv),
    .raddr(wt_raddr), .rdata(w_rd)
  );

  wlsfg_ram #(.WIDTH(VB + 1), .DEPTH(MAXLEN)) u_diff_row (
    .clk(clk), .we(el_we), .waddr(EAW'(row)), .wdata(diff_w),
    .raddr(i), .rdata(d_i)
  );

  wlsfg_ram #(.WIDTH(VB + 1), .DEPTH(MAXLEN)) u_diff_col (
    .clk(clk), .we(el_we), .waddr(EAW'(row)), .wdata(diff_w),
    .raddr(j), .rdata(d_j)
  );

  wlsfg_ram #(.WIDTH(VB), .DEPTH(MAXLEN)) u_deriv (
    .clk(clk), .we(el_we), .waddr(EAW'(row)), .wdata(gv),
    .raddr(j), .rdata(g_rd)
  );

  wlsfg_mac #(.MAX_VARS(MAX_VARS), .DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk(clk), .rst(rst), .ctl(ctl), .d_i(d_i), .d_j(d_j), .g_j(g_rd),
    .w(w_rd), .result(mac_res), .sat(mac_sat)
  );

`ifndef ASSERT_OFF
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (cmd == CMD_FIT || cmd == CMD_GRAD) |=> state == ST_RUN)
    else $error("compute command did not start the matrix walk");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> int'(wt_raddr) < WDEPTH)
    else $error("weight read address out of range");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[62:0] == {63{~m_tdata[63]}})
    else $error("saturated result is not a bound");
`endif

endmodule
